### rtl/fcc_pkg.sv
// fcc_pkg: shared types, sizes and helpers for the fifo replaced chunk cache
// used by fcc_tags and the core top level; depends on nothing else
`default_nettype none

package fcc_pkg;

    localparam int ENTRIES     = 12;
    localparam int CHUNK_WORDS = 1024;
    localparam int ROW_LENGTH  = 32;
    localparam int TILE_BITS   = 16;

    localparam int SLOT_W   = $clog2(ENTRIES);
    localparam int FILL_W   = $clog2(CHUNK_WORDS + 1);
    localparam int OFFSET_W = $clog2(CHUNK_WORDS);
    localparam int LIN_W    = 5 + $clog2(ROW_LENGTH) + 1;
    localparam int DEPTH    = ENTRIES * CHUNK_WORDS;
    localparam int ADDR_W   = $clog2(DEPTH);

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] chunk_number;
        logic [15:0] tile_word;
        logic [4:0]  col;
        logic [4:0]  row;
    } in_t;

    typedef struct packed {
        logic        hit;
        logic        complete;
        logic [15:0] tile_value;
    } out_t;

    // lookup answer from the tag array
    typedef struct packed {
        logic              hit;
        logic              complete;
        logic [SLOT_W-1:0] slot;
    } lkp_t;

    // append write request from the tag array
    typedef struct packed {
        logic                we;
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] offset;
    } app_t;

    function automatic logic [TILE_BITS-1:0] to_tile(input logic [15:0] w);
        logic [TILE_BITS+15:0] ext;
        ext = {{TILE_BITS{1'b0}}, w};
        return ext[TILE_BITS-1:0];
    endfunction

    function automatic logic [15:0] from_tile(input logic [TILE_BITS-1:0] t);
        logic [TILE_BITS+15:0] ext;
        ext = {16'd0, t};
        return ext[15:0];
    endfunction

    function automatic logic [ADDR_W-1:0] word_addr(
        input logic [SLOT_W-1:0]   slot,
        input logic [OFFSET_W-1:0] offset
    );
        return ADDR_W'(slot) * ADDR_W'(CHUNK_WORDS) + ADDR_W'(offset);
    endfunction

endpackage

`default_nettype wire

### rtl/fcc_ram.sv
// fcc_ram: generic single write port, single read port ram, registered read
// no package dependency
`default_nettype none

module fcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/fcc_tags.sv
// fcc_tags: tag, valid and complete bits per entry, fifo ring pointer and fill count
// depends on fcc_pkg
`default_nettype none

module fcc_tags (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cmd_valid,
    input  wire fcc_pkg::in_t cmd,
    output      fcc_pkg::lkp_t lkp,
    output      fcc_pkg::app_t app
);

    logic [15:0]                  tag_reg [fcc_pkg::ENTRIES];
    logic [fcc_pkg::ENTRIES-1:0]  valid_reg, valid_next;
    logic [fcc_pkg::ENTRIES-1:0]  comp_reg, comp_next;
    logic [fcc_pkg::SLOT_W-1:0]   oldest_reg, oldest_next;
    logic [fcc_pkg::FILL_W-1:0]   fill_reg, fill_next;

    logic [fcc_pkg::SLOT_W-1:0]   newest;
    logic [fcc_pkg::ENTRIES-1:0]  match;
    logic                         found_hi, found_any;
    logic [fcc_pkg::SLOT_W-1:0]   slot_hi, slot_any;
    logic                         do_alloc, do_append;

    assign newest = (oldest_reg == '0) ? fcc_pkg::SLOT_W'(fcc_pkg::ENTRIES - 1)
                                       : oldest_reg - 1'b1;
    assign do_alloc  = cmd_valid && (cmd.func == fcc_pkg::FUNC_ALLOC);
    assign do_append = cmd_valid && (cmd.func == fcc_pkg::FUNC_APPEND) && valid_reg[newest];

    // oldest match wins: first match at or after the ring pointer, else first overall
    always_comb begin
        found_hi  = 1'b0;
        found_any = 1'b0;
        slot_hi   = '0;
        slot_any  = '0;
        for (int i = fcc_pkg::ENTRIES - 1; i >= 0; i--) begin
            match[i] = valid_reg[i] && (tag_reg[i] == cmd.chunk_number);
            if (match[i]) begin
                found_any = 1'b1;
                slot_any  = fcc_pkg::SLOT_W'(i);
                if (fcc_pkg::SLOT_W'(i) >= oldest_reg) begin
                    found_hi = 1'b1;
                    slot_hi  = fcc_pkg::SLOT_W'(i);
                end
            end
        end
        lkp.hit      = found_any;
        lkp.slot     = found_hi ? slot_hi : slot_any;
        lkp.complete = found_any && comp_reg[lkp.slot];
    end

    always_comb begin
        app.we     = do_append && (fill_reg < fcc_pkg::FILL_W'(fcc_pkg::CHUNK_WORDS));
        app.slot   = newest;
        app.offset = fill_reg[fcc_pkg::OFFSET_W-1:0];
    end

    always_comb begin
        valid_next  = valid_reg;
        comp_next   = comp_reg;
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        if (do_alloc) begin
            valid_next[oldest_reg] = 1'b1;
            comp_next[oldest_reg]  = 1'b0;
            fill_next              = '0;
            oldest_next = (oldest_reg == fcc_pkg::SLOT_W'(fcc_pkg::ENTRIES - 1))
                        ? '0 : oldest_reg + 1'b1;
        end else if (do_append) begin
            if (app.we) begin
                fill_next         = fill_reg + 1'b1;
                comp_next[newest] = (fill_next == fcc_pkg::FILL_W'(fcc_pkg::CHUNK_WORDS));
            end else begin
                // extra word past a full chunk
                comp_next[newest] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            comp_reg   <= '0;
            oldest_reg <= '0;
            fill_reg   <= '0;
        end else begin
            valid_reg  <= valid_next;
            comp_reg   <= comp_next;
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_alloc) begin
            tag_reg[oldest_reg] <= cmd.chunk_number;
        end
    end

endmodule

`default_nettype wire

### rtl/fifo_replaced_chunk_cache_core.sv
// fifo_replaced_chunk_cache_core: top level of the chunk cache
// depends on fcc_pkg, fcc_tags and fcc_ram
`default_nettype none

// usage:
// - s_valid/s_ready/s_data carry one command transaction: allocate (func 0)
//   takes the oldest entry in fifo order for a new chunk tag, append (func 1)
//   writes the next tile word into the newest entry, lookup (func 2) searches
//   all entries, oldest match first; func 3 is ignored
// - m_valid/m_ready/m_data carry one result transaction per lookup only:
//   hit, complete and the tile word at row*32+col (zero on a miss or when the
//   index falls outside the chunk)
// - throughput is one transaction per cycle for any mix of commands while
//   s_ready is high; tag compare is parallel in flip-flops and the tile
//   store is one ram with one write and one registered read port
// - a lookup goes from acceptance to m_valid through the ram read stage,
//   then the output register
// - an append followed at once by a lookup of the same word is safe: the
//   write lands at the append's edge, before the lookup's read
// - when the receiver stalls, the output register holds its result and the
//   read stage holds one more; s_ready drops only when both are full
// - reset clears valid and complete bits, the ring pointer and the fill
//   count; the tile store is not cleared, no clearing pass is run
module fifo_replaced_chunk_cache_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output      logic          s_ready,
    input  wire fcc_pkg::in_t  s_data,
    output      logic          m_valid,
    input  wire logic          m_ready,
    output      fcc_pkg::out_t m_data
);

    fcc_pkg::lkp_t                 lkp;
    fcc_pkg::app_t                 app;
    logic                          s_accept;
    logic                          is_lookup;
    logic [fcc_pkg::LIN_W-1:0]     lin_idx;
    logic                          in_range;
    logic                          rd_en;
    logic [fcc_pkg::TILE_BITS-1:0] rd_data;

    // read stage
    logic p1_valid_reg, p1_valid_next;
    logic p1_hit_reg, p1_comp_reg, p1_rd_reg;
    logic p1_adv;

    // output register
    logic          m_valid_reg, m_valid_next;
    fcc_pkg::out_t m_data_reg;

    assign p1_adv   = !m_valid_reg || m_ready;
    assign s_ready  = !p1_valid_reg || p1_adv;
    assign s_accept = s_valid && s_ready;

    assign is_lookup = (s_data.func == fcc_pkg::FUNC_LOOKUP);
    assign lin_idx   = fcc_pkg::LIN_W'(s_data.row) * fcc_pkg::LIN_W'(fcc_pkg::ROW_LENGTH)
                     + fcc_pkg::LIN_W'(s_data.col);
    assign in_range  = (lin_idx < fcc_pkg::LIN_W'(fcc_pkg::CHUNK_WORDS));
    assign rd_en     = s_accept && is_lookup && lkp.hit && in_range;

    fcc_tags u_tags (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_accept),
        .cmd       (s_data),
        .lkp       (lkp),
        .app       (app)
    );

    fcc_ram #(
        .WIDTH (fcc_pkg::TILE_BITS),
        .DEPTH (fcc_pkg::DEPTH)
    ) u_tile_ram (
        .aclk  (aclk),
        .we    (s_accept && app.we),
        .waddr (fcc_pkg::word_addr(app.slot, app.offset)),
        .wdata (fcc_pkg::to_tile(s_data.tile_word)),
        .re    (rd_en),
        .raddr (fcc_pkg::word_addr(lkp.slot, lin_idx[fcc_pkg::OFFSET_W-1:0])),
        .rdata (rd_data)
    );

    // stage control: new lookup enters read stage, read stage drains to output
    always_comb begin
        p1_valid_next = p1_valid_reg;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (p1_valid_reg && p1_adv) begin
            m_valid_next  = 1'b1;
            p1_valid_next = 1'b0;
        end
        if (s_accept && is_lookup) begin
            p1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept && is_lookup) begin
            p1_hit_reg  <= lkp.hit;
            p1_comp_reg <= lkp.complete;
            p1_rd_reg   <= rd_en;
        end
        if (p1_valid_reg && p1_adv) begin
            m_data_reg.hit        <= p1_hit_reg;
            m_data_reg.complete   <= p1_comp_reg;
            m_data_reg.tile_value <= p1_rd_reg ? fcc_pkg::from_tile(rd_data) : 16'd0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
